// File: hdl/ipq_pkg.sv
// Shared types and constants for the impairing packet queue.
package ipq_pkg;

  localparam int TAG_W        = 16;
  localparam int LEN_W        = 16;
  localparam int DRAW_W       = 16;
  localparam int BYTE_W       = 24;
  localparam int PKT_W        = 8;
  localparam int TAG_MAX_BITS = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int S_TDATA_W    = 48;
  localparam int M_TDATA_W    = 88;

  localparam logic [PKT_W-1:0]  MAX_PACKETS_RST = PKT_W'(100);
  localparam logic [BYTE_W-1:0] MAX_BYTES_RST   = BYTE_W'(100 * 65535);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    STAT_ACCEPTED    = 3'd0,
    STAT_FULL_PKTS   = 3'd1,
    STAT_FULL_BYTES  = 3'd2,
    STAT_RANDOM_DROP = 3'd3,
    STAT_NOT_ENQ     = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT_MODE     = 3'd0,
    CFG_MAX_PACKETS    = 3'd1,
    CFG_MAX_BYTES      = 3'd2,
    CFG_DROP_THRESHOLD = 3'd3,
    CFG_WINDOW_SIZE    = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    IDLE,
    EXEC,
    FLUSH,
    HEAD_RD,
    RESULT
  } state_t;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_FIFO,
    SRC_WIN
  } src_t;

  typedef struct packed {
    logic              limit_mode;
    logic [PKT_W-1:0]  max_packets;
    logic [BYTE_W-1:0] max_bytes;
    logic [DRAW_W-1:0] drop_threshold;
    logic [4:0]        window_size;
  } cfg_t;

  typedef struct packed {
    op_t               opcode;
    logic [TAG_W-1:0]  packet_tag;
    logic [LEN_W-1:0]  packet_length;
    logic [DRAW_W-1:0] random_draw;
  } req_t;

  typedef struct packed {
    status_t           enqueue_status;
    logic              dequeue_valid;
    logic [TAG_W-1:0]  dequeue_tag;
    logic [LEN_W-1:0]  dequeue_length;
    logic              head_valid;
    logic [TAG_W-1:0]  head_tag;
    logic [PKT_W-1:0]  packets_held;
    logic [BYTE_W-1:0] bytes_held;
  } res_t;

endpackage

// File: hdl/ipq_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module ipq_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/ipq_ctrl.sv
// Request sequencer: limit checks, FIFO and reorder-window pointers, flush and head reads.
module ipq_ctrl #(
  parameter int FIFO_DEPTH   = 2,
  parameter int WINDOW_DEPTH = 1,
  parameter int TAG_BITS     = 16,
  localparam int AW  = $clog2(FIFO_DEPTH),
  localparam int WAW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
  localparam int EW  = TAG_BITS + 16
) (
  input  logic                clk,
  input  logic                rst,
  input  ipq_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  ipq_pkg::req_t       in_req,
  output logic                res_valid,
  input  logic                res_ready,
  output ipq_pkg::res_t       res,
  output logic                fifo_we,
  output logic [AW-1:0]       fifo_waddr,
  output logic [EW-1:0]       fifo_wdata,
  output logic                fifo_re,
  output logic [AW-1:0]       fifo_raddr,
  input  logic [EW-1:0]       fifo_rdata,
  output logic                win_we,
  output logic [WAW-1:0]      win_waddr,
  output logic [EW-1:0]       win_wdata,
  output logic                win_re,
  output logic [WAW-1:0]      win_raddr,
  input  logic [EW-1:0]       win_rdata
);
  import ipq_pkg::*;

  localparam int CW  = $clog2(FIFO_DEPTH + 1);
  localparam int WCW = $clog2(WINDOW_DEPTH + 1);
  localparam int HW  = $clog2(FIFO_DEPTH + WINDOW_DEPTH + 1);
  localparam int PW  = (HW > PKT_W) ? HW : PKT_W;
  localparam int XW  = (WCW > 5) ? WCW : 5;

  state_t            state, state_next;
  req_t              req, req_next;
  status_t           status, status_next;
  logic              dv, dv_next;
  logic [TAG_W-1:0]  dtag, dtag_next;
  logic [LEN_W-1:0]  dlen, dlen_next;
  src_t              deq_src, deq_src_next;
  src_t              head_src, head_src_next;
  logic [AW-1:0]     rp, rp_next, wp, wp_next, rp_inc, wp_inc;
  logic [CW-1:0]     fcnt, fcnt_next;
  logic [WCW-1:0]    wc, wc_next, wc_m1;
  logic [BYTE_W-1:0] byte_total, byte_total_next;
  logic              mv_pend, mv_pend_next;

  logic [PW-1:0]     held;
  logic [BYTE_W:0]   sum;
  logic [XW-1:0]     win_size_x, eff_win, wc_inc_x;
  logic              use_win;
  status_t           enq_status;
  logic [TAG_MAX_BITS-1:0] tag_wide, ftag_wide, wtag_wide;
  logic [EW-1:0]     entry_in;
  logic [LEN_W-1:0]  deq_len;
  logic [TAG_W-1:0]  fifo_tag, win_tag;

  always_comb begin
    held       = PW'(fcnt) + PW'(wc);
    sum        = {1'b0, byte_total} + {{(BYTE_W + 1 - LEN_W){1'b0}}, req.packet_length};
    win_size_x = XW'(cfg.window_size);
    eff_win    = (win_size_x > XW'(WINDOW_DEPTH)) ? XW'(WINDOW_DEPTH) : win_size_x;
    wc_inc_x   = XW'(wc) + XW'(1);
    use_win    = (eff_win != '0) && (wc < WCW'(WINDOW_DEPTH));
    wc_m1      = wc - WCW'(1);
    rp_inc     = (rp == AW'(FIFO_DEPTH - 1)) ? '0 : rp + AW'(1);
    wp_inc     = (wp == AW'(FIFO_DEPTH - 1)) ? '0 : wp + AW'(1);
    tag_wide   = TAG_MAX_BITS'(req.packet_tag);
    entry_in   = {req.packet_length, tag_wide[TAG_BITS-1:0]};
    ftag_wide  = TAG_MAX_BITS'(fifo_rdata[TAG_BITS-1:0]);
    wtag_wide  = TAG_MAX_BITS'(win_rdata[TAG_BITS-1:0]);
    fifo_tag   = ftag_wide[TAG_W-1:0];
    win_tag    = wtag_wide[TAG_W-1:0];
    deq_len    = (deq_src == SRC_WIN) ? win_rdata[TAG_BITS +: LEN_W]
                                      : fifo_rdata[TAG_BITS +: LEN_W];

    if (!cfg.limit_mode && held >= PW'(cfg.max_packets)) begin
      enq_status = STAT_FULL_PKTS;
    end else if (cfg.limit_mode && sum >= {1'b0, cfg.max_bytes}) begin
      enq_status = STAT_FULL_BYTES;
    end else if (held >= PW'(FIFO_DEPTH)) begin
      enq_status = STAT_FULL_PKTS;
    end else if (sum[BYTE_W]) begin
      enq_status = STAT_FULL_BYTES;
    end else if (cfg.drop_threshold != '0 && req.random_draw < cfg.drop_threshold) begin
      enq_status = STAT_RANDOM_DROP;
    end else begin
      enq_status = STAT_ACCEPTED;
    end
  end

  always_comb begin
    state_next      = state;
    req_next        = req;
    status_next     = status;
    dv_next         = dv;
    dtag_next       = dtag;
    dlen_next       = dlen;
    deq_src_next    = deq_src;
    head_src_next   = head_src;
    rp_next         = rp;
    wp_next         = wp;
    fcnt_next       = fcnt;
    wc_next         = wc;
    byte_total_next = byte_total;
    mv_pend_next    = mv_pend;
    in_ready        = 1'b0;
    res_valid       = 1'b0;
    fifo_we         = 1'b0;
    fifo_waddr      = wp;
    fifo_wdata      = entry_in;
    fifo_re         = 1'b0;
    fifo_raddr      = rp;
    win_we          = 1'b0;
    win_waddr       = wc[WAW-1:0];
    win_wdata       = entry_in;
    win_re          = 1'b0;
    win_raddr       = wc_m1[WAW-1:0];

    unique case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_next   = in_req;
          state_next = EXEC;
        end
      end
      EXEC: begin
        deq_src_next = SRC_NONE;
        state_next   = HEAD_RD;
        if (req.opcode == OP_ENQ) begin
          status_next = enq_status;
          if (enq_status == STAT_ACCEPTED) begin
            byte_total_next = sum[BYTE_W-1:0];
            if (use_win) begin
              win_we  = 1'b1;
              wc_next = wc + WCW'(1);
              if (wc_inc_x >= eff_win) begin
                mv_pend_next = 1'b0;
                state_next   = FLUSH;
              end
            end else if (fcnt < CW'(FIFO_DEPTH)) begin
              fifo_we   = 1'b1;
              wp_next   = wp_inc;
              fcnt_next = fcnt + CW'(1);
            end
          end
        end else begin
          status_next = STAT_NOT_ENQ;
          if (fcnt != '0) begin
            fifo_re      = 1'b1;
            rp_next      = rp_inc;
            fcnt_next    = fcnt - CW'(1);
            deq_src_next = SRC_FIFO;
          end else if (wc != '0) begin
            win_re       = 1'b1;
            wc_next      = wc_m1;
            deq_src_next = SRC_WIN;
          end
        end
      end
      FLUSH: begin
        // read window top while writing the previous entry into the FIFO
        fifo_wdata = win_rdata;
        if (mv_pend && fcnt < CW'(FIFO_DEPTH)) begin
          fifo_we   = 1'b1;
          wp_next   = wp_inc;
          fcnt_next = fcnt + CW'(1);
        end
        if (wc != '0) begin
          win_re       = 1'b1;
          wc_next      = wc_m1;
          mv_pend_next = 1'b1;
        end else begin
          mv_pend_next = 1'b0;
          state_next   = HEAD_RD;
        end
      end
      HEAD_RD: begin
        dv_next   = 1'b0;
        dtag_next = '0;
        dlen_next = '0;
        if (deq_src != SRC_NONE) begin
          dv_next         = 1'b1;
          dtag_next       = (deq_src == SRC_WIN) ? win_tag : fifo_tag;
          dlen_next       = deq_len;
          byte_total_next = (byte_total >= BYTE_W'(deq_len))
                            ? byte_total - BYTE_W'(deq_len) : '0;
        end
        if (fcnt != '0) begin
          fifo_re       = 1'b1;
          head_src_next = SRC_FIFO;
        end else if (wc != '0) begin
          win_re        = 1'b1;
          head_src_next = SRC_WIN;
        end else begin
          head_src_next = SRC_NONE;
        end
        state_next = RESULT;
      end
      RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          in_ready = 1'b1;
          if (in_valid) begin
            req_next   = in_req;
            state_next = EXEC;
          end else begin
            state_next = IDLE;
          end
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_comb begin
    res.enqueue_status = status;
    res.dequeue_valid  = dv;
    res.dequeue_tag    = dtag;
    res.dequeue_length = dlen;
    res.head_valid     = (head_src != SRC_NONE);
    case (head_src)
      SRC_FIFO: res.head_tag = fifo_tag;
      SRC_WIN:  res.head_tag = win_tag;
      default:  res.head_tag = '0;
    endcase
    res.packets_held = held[PKT_W-1:0];
    res.bytes_held   = byte_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp         <= '0;
      wp         <= '0;
      fcnt       <= '0;
      wc         <= '0;
      byte_total <= '0;
      mv_pend    <= 1'b0;
      deq_src    <= SRC_NONE;
      head_src   <= SRC_NONE;
    end else begin
      rp         <= rp_next;
      wp         <= wp_next;
      fcnt       <= fcnt_next;
      wc         <= wc_next;
      byte_total <= byte_total_next;
      mv_pend    <= mv_pend_next;
      deq_src    <= deq_src_next;
      head_src   <= head_src_next;
    end
  end

  always_ff @(posedge clk) begin
    req    <= req_next;
    status <= status_next;
    dv     <= dv_next;
    dtag   <= dtag_next;
    dlen   <= dlen_next;
  end

endmodule

// File: hdl/impairing_packet_queue_top.sv
// Top level of the impairing packet queue: config registers, RAMs, sequencer, output register.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tuser opcode; s_tdata tag, length, draw
//  m_*       out  m_tvalid/m_tready  m_tdata result fields
//  cfg_*     in   cfg_we             cfg_index, cfg_data
//
// Each request passes through the evaluate, head read and result steps.
// An enqueue that fills the reorder window then moves its n entries into the FIFO, one per
// cycle through the single read port of the window RAM.
// rst is synchronous; pointers, counts and the byte total clear, RAM contents do not.
// A held result stalls the sequencer in its result step; the next request is taken
// in the same cycle the result is moved into the output register.
module impairing_packet_queue_top #(
  parameter int FIFO_DEPTH   = 128,
  parameter int WINDOW_DEPTH = 16,
  parameter int TAG_BITS     = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ipq_pkg::S_TDATA_W-1:0]     s_tdata,   // packet_tag, packet_length, random_draw
  input  logic                              s_tuser,   // opcode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ipq_pkg::M_TDATA_W-1:0]     m_tdata,   // enqueue_status, dequeue_valid,
                                                       // dequeue_tag, dequeue_length,
                                                       // head_valid, head_tag,
                                                       // packets_held, bytes_held, pad
  input  logic                              cfg_we,
  input  logic [ipq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ipq_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ipq_pkg::*;

  localparam int AW  = $clog2(FIFO_DEPTH);
  localparam int WAW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int EW  = TAG_BITS + 16;

  cfg_t           cfg;
  req_t           in_req;
  res_t           res, out_q;
  logic           res_valid, res_ready;
  logic           fifo_we, fifo_re, win_we, win_re;
  logic [AW-1:0]  fifo_waddr, fifo_raddr;
  logic [WAW-1:0] win_waddr, win_raddr;
  logic [EW-1:0]  fifo_wdata, fifo_rdata, win_wdata, win_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.limit_mode     <= 1'b0;
      cfg.max_packets    <= MAX_PACKETS_RST;
      cfg.max_bytes      <= MAX_BYTES_RST;
      cfg.drop_threshold <= '0;
      cfg.window_size    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LIMIT_MODE:     cfg.limit_mode     <= cfg_data[0];
        CFG_MAX_PACKETS:    cfg.max_packets    <= cfg_data[PKT_W-1:0];
        CFG_MAX_BYTES:      cfg.max_bytes      <= cfg_data[BYTE_W-1:0];
        CFG_DROP_THRESHOLD: cfg.drop_threshold <= cfg_data[DRAW_W-1:0];
        CFG_WINDOW_SIZE:    cfg.window_size    <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign in_req.opcode        = op_t'(s_tuser);
  assign in_req.packet_tag    = s_tdata[TAG_W-1:0];
  assign in_req.packet_length = s_tdata[TAG_W +: LEN_W];
  assign in_req.random_draw   = s_tdata[TAG_W + LEN_W +: DRAW_W];

  ipq_ram #(.DEPTH(FIFO_DEPTH), .WIDTH(EW)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (fifo_wdata),
    .re    (fifo_re),
    .raddr (fifo_raddr),
    .rdata (fifo_rdata)
  );

  ipq_ram #(.DEPTH(WINDOW_DEPTH), .WIDTH(EW)) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (win_wdata),
    .re    (win_re),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  ipq_ctrl #(
    .FIFO_DEPTH   (FIFO_DEPTH),
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .TAG_BITS     (TAG_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_req     (in_req),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .fifo_we    (fifo_we),
    .fifo_waddr (fifo_waddr),
    .fifo_wdata (fifo_wdata),
    .fifo_re    (fifo_re),
    .fifo_raddr (fifo_raddr),
    .fifo_rdata (fifo_rdata),
    .win_we     (win_we),
    .win_waddr  (win_waddr),
    .win_wdata  (win_wdata),
    .win_re     (win_re),
    .win_raddr  (win_raddr),
    .win_rdata  (win_rdata)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_tdata = {3'b000,
                    out_q.bytes_held,
                    out_q.packets_held,
                    out_q.head_tag,
                    out_q.head_valid,
                    out_q.dequeue_length,
                    out_q.dequeue_tag,
                    out_q.dequeue_valid,
                    out_q.enqueue_status};

  a_deq_only_on_dequeue: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_q.dequeue_valid |-> out_q.enqueue_status == STAT_NOT_ENQ)
    else $error("dequeued packet reported on an enqueue");

  a_deq_fields_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_q.dequeue_valid |->
      out_q.dequeue_tag == '0 && out_q.dequeue_length == '0)
    else $error("dequeue fields set without a dequeued packet");

  a_head_tag_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_q.head_valid |-> out_q.head_tag == '0)
    else $error("head tag set while queue is empty");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in progress");

endmodule
